@@ rtl/tsme_pkg.sv @@
// Shared types and constants for the tiny stack machine executor.
// Used by the top level, the stack memory and the port checker; no dependencies.
package tsme_pkg;

    // Opcode names; OP_NOP and every code not listed here are no-ops.
    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUT  = 3'd1,
        OP_ADD  = 3'd2,
        OP_JZ   = 3'd3,
        OP_JMP  = 3'd4,
        OP_SWAP = 3'd7
    } op_code_t;

    // Fault codes reported with each result word.
    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_EMPTY = 2'd1,
        FAULT_FULL  = 2'd2
    } fault_t;

    // The program counter always halts the machine at this address.
    localparam logic [5:0] PC_LIMIT        = 6'd32;
    localparam logic [5:0] PROG_LEN_RESET  = 6'd32;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] arg;
    } tsme_in_t;

    typedef struct packed {
        logic [5:0]  next_pc;
        logic [31:0] top_value;
        logic [5:0]  depth;
        logic        halted;
        logic [1:0]  fault;
    } tsme_out_t;

endpackage

@@ rtl/tiny_stack_machine_executor.sv @@
// Tiny stack machine executor: one instruction word in, one status word out.
// Instruction words pass the input register, then the result register.
// Throughput: one instruction per cycle unless out_ready stalls, set by the single
// execute stage and the one-read, one-write stack memory (top of stack in a register).
// Reset (rst_n, async, active low): empty stack reading as zeros, pc 0, running,
// program length 32; memory entries need no clearing pass thanks to valid bits.
module tiny_stack_machine_executor
    import tsme_pkg::*;
#(
    parameter int STACK_ENTRIES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tsme_in_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output tsme_out_t out_word,
    input  logic      cfg_we,
    input  logic [5:0] cfg_wdata
);

    localparam int         IW  = $clog2(STACK_ENTRIES);
    localparam logic [5:0] SE6 = 6'(STACK_ENTRIES);

    logic        inq_valid_reg;
    tsme_in_t    inq_reg;
    logic        out_valid_reg;
    tsme_out_t   out_reg;

    logic [5:0]  depth_reg, depth_next;
    logic [5:0]  pc_reg, pc_next;
    logic        stopped_reg, stopped_next;
    logic [31:0] top_reg, top_next;
    logic [5:0]  plen_reg;

    logic        commit;
    logic        accept;
    logic [5:0]  depth_m1;
    logic        arg_ok;
    logic        arg_is_top;
    logic [IW-1:0] arg_idx;
    fault_t      fault_c;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [31:0] rd_word;

    // Handshake: the execute stage retires when the result register is free.
    assign commit    = inq_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !inq_valid_reg || commit;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            inq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inq_reg <= in_word;
        end
    end

    // Stack memory; the top word lives in top_reg, below it in memory.
    tsme_stack #(
        .ENTRIES (STACK_ENTRIES)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (in_word.arg[IW-1:0]),
        .rd_word (rd_word)
    );

    assign depth_m1   = depth_reg - 6'd1;
    assign arg_idx    = inq_reg.arg[IW-1:0];
    assign arg_ok     = {1'b0, inq_reg.arg} < SE6;
    assign arg_is_top = {1'b0, inq_reg.arg} == depth_m1;

    // Execute one instruction against the current machine state.
    always_comb
    begin
        depth_next   = depth_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        top_next     = top_reg;
        fault_c      = FAULT_NONE;
        wr_en        = 1'b0;
        wr_addr      = arg_idx;
        wr_data      = top_reg;

        if (!stopped_reg)
        begin
            unique case (inq_reg.op)
                OP_PUT:
                begin
                    if (depth_reg >= SE6)
                    begin
                        fault_c = FAULT_FULL;
                    end
                    else
                    begin
                        // Spill the old top into memory before the new top replaces it.
                        if (depth_reg != 6'd0)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = depth_m1[IW-1:0];
                        end
                        top_next   = {27'd0, inq_reg.arg};
                        depth_next = depth_reg + 6'd1;
                    end
                end
                OP_ADD:
                begin
                    if (depth_reg == 6'd0)
                    begin
                        fault_c = FAULT_EMPTY;
                    end
                    else if (arg_ok)
                    begin
                        if (arg_is_top)
                        begin
                            top_next = top_reg + top_reg;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_word + top_reg;
                        end
                    end
                end
                OP_JZ:
                begin
                    if (depth_reg == 6'd0)
                    begin
                        fault_c = FAULT_EMPTY;
                    end
                    else if (top_reg == 32'd0)
                    begin
                        pc_next = {1'b0, inq_reg.arg};
                    end
                end
                OP_JMP:
                begin
                    pc_next = {1'b0, inq_reg.arg};
                end
                OP_SWAP:
                begin
                    if (depth_reg == 6'd0)
                    begin
                        fault_c = FAULT_EMPTY;
                    end
                    else if (arg_ok && !arg_is_top)
                    begin
                        wr_en    = 1'b1;
                        top_next = rd_word;
                    end
                end
                default:
                begin
                end
            endcase

            // An unchanged counter steps forward, then the halt check.
            if (pc_next == pc_reg)
            begin
                pc_next = pc_reg + 6'd1;
            end
            stopped_next = (pc_next == PC_LIMIT) || (pc_next == plen_reg);
        end

        wr_en = wr_en && commit;
    end

    // Machine state, updated when an instruction retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= 6'd0;
            pc_reg      <= 6'd0;
            stopped_reg <= 1'b0;
            top_reg     <= 32'd0;
        end
        else if (commit)
        begin
            depth_reg   <= depth_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            top_reg     <= top_next;
        end
    end

    // Program length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= PROG_LEN_RESET;
        end
        else if (cfg_we)
        begin
            plen_reg <= cfg_wdata;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg.next_pc   <= pc_next;
            out_reg.top_value <= top_next;
            out_reg.depth     <= depth_next;
            out_reg.halted    <= stopped_next;
            out_reg.fault     <= fault_c;
        end
    end

endmodule

@@ rtl/tsme_stack.sv @@
// Stack word memory: one write port, one registered read port with write bypass.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses tsme_pkg.
module tsme_stack
    import tsme_pkg::*;
#(
    parameter int ENTRIES = 32,
    localparam int IW = $clog2(ENTRIES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [31:0]   rd_word
);

    logic [31:0]        mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    logic [31:0]        mem_q_reg;
    logic               vld_q_reg;
    logic               byp_hit_reg;
    logic [31:0]        byp_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Entry valid bits, cleared together at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read; a write to the same address at the same edge is bypassed.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            vld_q_reg    <= vld_reg[rd_addr];
            byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_word = byp_hit_reg ? byp_data_reg : (vld_q_reg ? mem_q_reg : 32'd0);

endmodule

@@ rtl/tsme_checker.sv @@
// Port-level checks for the tiny stack machine executor, bound to the top level.
// Uses tsme_pkg for the word types and fault codes.
module tsme_port_assert
    import tsme_pkg::*;
#(
    parameter int STACK_ENTRIES = 32
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input tsme_in_t  in_word,
    input logic      out_valid,
    input logic      out_ready,
    input tsme_out_t out_word
);

    // An instruction word waiting for acceptance stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("instruction word dropped or changed while waiting");

    // A stalled result word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("result word changed while stalled");

    // No result word is offered right after reset releases.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // A full-stack fault only happens with the stack at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.fault == FAULT_FULL)
            |-> (out_word.depth == 6'(STACK_ENTRIES)) && !out_word.halted
                || (out_word.depth == 6'(STACK_ENTRIES)))
        else $error("full fault with stack not full");

    // An empty-stack fault leaves the stack empty and the top reading zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.fault == FAULT_EMPTY)
            |-> (out_word.depth == 6'd0) && (out_word.top_value == 32'd0))
        else $error("empty fault with stack not empty");

endmodule

bind tiny_stack_machine_executor tsme_port_assert #(
    .STACK_ENTRIES (STACK_ENTRIES)
) u_tsme_port_assert (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
